// ===== hw/rtl/uv_sphere_vertex_generator_assert.svh =====
// assertion macros for the uv sphere vertex generator checker
`ifndef UV_SPHERE_VERTEX_GENERATOR_ASSERT_SVH
`define UV_SPHERE_VERTEX_GENERATOR_ASSERT_SVH

// same-cycle implication
`define UVS_ASSERT_NOW(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("uvs assertion failed");

// next-cycle implication
`define UVS_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("uvs assertion failed");

`endif

// ===== hw/rtl/uvs_pkg.sv =====
// shared constants, types and functions for the uv sphere vertex generator
`timescale 1ns / 1ps
`default_nettype none
package uvs_pkg;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd2;

  localparam int CNT_W    = 9;
  localparam int RADIUS_W = 16;
  localparam int FIELD_W  = 17;
  localparam int TEX_SHIFT = 16;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 34;
  localparam int Z_W          = 33;
  localparam int TRIG_W       = 32;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam int SCALE_LAT    = 3;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CORDIC_W-1:0] ONE_Q30     = 34'sd1073741824;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic [FIELD_W-1:0] field_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] a;
    case (i)
      0: a = 32'h20000000;  1: a = 32'h12E4051D;  2: a = 32'h09FB385B;
      3: a = 32'h051111D4;  4: a = 32'h028B0D43;  5: a = 32'h0145D7E1;
      6: a = 32'h00A2F61E;  7: a = 32'h00517C55;  8: a = 32'h0028BE53;
      9: a = 32'h00145F2E; 10: a = 32'h000A2F98; 11: a = 32'h000517CC;
      12: a = 32'h00028BE6; 13: a = 32'h000145F3; 14: a = 32'h0000A2F9;
      15: a = 32'h0000517C; 16: a = 32'h000028BE; 17: a = 32'h0000145F;
      18: a = 32'h00000A2F; 19: a = 32'h00000517; 20: a = 32'h0000028B;
      21: a = 32'h00000145; 22: a = 32'h000000A2; 23: a = 32'h00000051;
      24: a = 32'h00000028; 25: a = 32'h00000014; 26: a = 32'h0000000A;
      27: a = 32'h00000005; 28: a = 32'h00000002; 29: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  // divide by 2^30, round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + 64'sd536870912 - (v[63] ? 64'sd1 : 64'sd0);
    return t >>> 30;
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/uvs_div_lane.sv =====
// pipelined rounded divider lane, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module uvs_div_lane #(
  parameter int IW = 9,
  parameter int QW = 17,
  parameter int SHIFT = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          vin,
  input  wire logic [IW-1:0] idx,
  input  wire logic [IW-1:0] cnt,
  output logic               vout,
  output logic [QW-1:0]      quo
);
  localparam int NW = IW + QW + 1;
  localparam int DW = IW + 1;

  logic [NW-1:0] numer;
  logic [DW-1:0] den;
  logic [DW-1:0] rem [QW];
  logic [QW-1:0] low [QW];
  logic [QW-1:0] qacc [QW];
  logic          v [QW];

  assign numer = (NW'(idx) << (SHIFT + 1)) + NW'(cnt);
  assign den   = {cnt, 1'b0};

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW-1:0] r_src;
    logic [QW-1:0] l_src;
    logic [QW-1:0] q_src;
    logic          v_src;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          qbit;
    if (s == 0) begin : g_first
      assign r_src = numer[NW-1:QW];
      assign l_src = numer[QW-1:0];
      assign q_src = '0;
      assign v_src = vin;
    end else begin : g_rest
      assign r_src = rem[s-1];
      assign l_src = low[s-1];
      assign q_src = qacc[s-1];
      assign v_src = v[s-1];
    end
    always_comb begin
      t    = {r_src, l_src[QW-1]};
      diff = t - {1'b0, den};
      qbit = (t >= {1'b0, den});
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en) begin
        v[s] <= v_src;
      end
      if (en) begin
        rem[s]  <= qbit ? diff[DW-1:0] : t[DW-1:0];
        low[s]  <= {l_src[QW-2:0], 1'b0};
        qacc[s] <= {q_src[QW-2:0], qbit};
      end
    end
  end

  assign vout = v[QW-1];
  assign quo  = qacc[QW-1];
endmodule
`default_nettype wire

// ===== hw/rtl/uvs_cordic.sv =====
// pipelined cordic sine and cosine of a phase, q2.30 results
`timescale 1ns / 1ps
`default_nettype none
module uvs_cordic #(
  parameter int PB = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          vin,
  input  wire logic [PB-1:0] phase,
  output logic               vout,
  output uvs_pkg::trig_t     cos_o,
  output uvs_pkg::trig_t     sin_o
);
  import uvs_pkg::*;

  logic [31:0] wide;
  logic signed [CORDIC_W-1:0] x [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] y [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]      z [CORDIC_STEPS+1];
  logic [1:0]                 q [CORDIC_STEPS+1];
  logic                       v [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] cx, cy;
  trig_t tx, ty;
  logic vfin;

  assign wide = {phase, {(32-PB){1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= vin;
    end
    if (en) begin
      x[0] <= CORDIC_GAIN;
      y[0] <= '0;
      z[0] <= {3'b000, wide[29:0]};
      q[0] <= wide[31:30];
    end
  end

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_iter
    logic signed [CORDIC_W-1:0] dx, dy;
    logic signed [Z_W-1:0] at;
    assign dx = x[s] >>> s;
    assign dy = y[s] >>> s;
    assign at = $signed({1'b0, atan_turn(s)});
    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
      if (en) begin
        q[s+1] <= q[s];
        if (!z[s][Z_W-1]) begin
          x[s+1] <= x[s] - dy;
          y[s+1] <= y[s] + dx;
          z[s+1] <= z[s] - at;
        end else begin
          x[s+1] <= x[s] + dy;
          y[s+1] <= y[s] - dx;
          z[s+1] <= z[s] + at;
        end
      end
    end
  end

  always_comb begin
    cx = x[CORDIC_STEPS];
    cy = y[CORDIC_STEPS];
    if (cx > ONE_Q30) cx = ONE_Q30;
    if (cx < -ONE_Q30) cx = -ONE_Q30;
    if (cy > ONE_Q30) cy = ONE_Q30;
    if (cy < -ONE_Q30) cy = -ONE_Q30;
    tx = cx[TRIG_W-1:0];
    ty = cy[TRIG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vfin <= 1'b0;
    end else if (en) begin
      vfin <= v[CORDIC_STEPS];
    end
    if (en) begin
      case (q[CORDIC_STEPS])
        2'd0: begin cos_o <= tx;  sin_o <= ty;  end
        2'd1: begin cos_o <= -ty; sin_o <= tx;  end
        2'd2: begin cos_o <= -tx; sin_o <= -ty; end
        default: begin cos_o <= ty; sin_o <= -tx; end
      endcase
    end
  end

  assign vout = vfin;
endmodule
`default_nettype wire

// ===== hw/rtl/uvs_scale.sv =====
// products of trig terms and radius, rounded to q8.8 positions
`timescale 1ns / 1ps
`default_nettype none
module uvs_scale (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          vin,
  input  wire logic [uvs_pkg::RADIUS_W-1:0]  radius,
  input  uvs_pkg::trig_t                     cs,
  input  uvs_pkg::trig_t                     ss,
  input  uvs_pkg::trig_t                     cc,
  input  uvs_pkg::trig_t                     sc,
  output logic                               vout,
  output uvs_pkg::field_t                    px,
  output uvs_pkg::field_t                    py,
  output uvs_pkg::field_t                    pz
);
  import uvs_pkg::*;

  logic signed [RADIUS_W:0] rs;
  logic signed [48:0] m1_y;
  logic signed [63:0] m1_x, m1_z;
  logic signed [17:0] m2_y;
  trig_t m2_x, m2_z;
  logic signed [17:0] m3_y;
  logic signed [48:0] m3_x, m3_z;
  logic signed [63:0] r2_y, r2_x, r2_z, r4_x, r4_z;
  logic v1, v2, v3;

  assign rs   = $signed({1'b0, radius});
  assign r2_y = rnd30(64'(m1_y));
  assign r2_x = rnd30(m1_x);
  assign r2_z = rnd30(m1_z);
  assign r4_x = rnd30(64'(m3_x));
  assign r4_z = rnd30(64'(m3_z));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= vin;
      v2 <= v1;
      v3 <= v2;
    end
    if (en) begin
      m1_y <= rs * ss;
      m1_x <= cs * cc;
      m1_z <= cs * sc;
      m2_y <= r2_y[17:0];
      m2_x <= r2_x[TRIG_W-1:0];
      m2_z <= r2_z[TRIG_W-1:0];
      m3_y <= m2_y;
      m3_x <= rs * m2_x;
      m3_z <= rs * m2_z;
    end
  end

  assign vout = v3;
  assign px   = r4_x[FIELD_W-1:0];
  assign py   = m3_y[FIELD_W-1:0];
  assign pz   = r4_z[FIELD_W-1:0];
endmodule
`default_nettype wire

// ===== hw/rtl/uv_sphere_vertex_generator.sv =====
// top level of the uv sphere vertex generator
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  stack_index, sector_index
//  out      output     out_valid/out_stall  pos, tex, normal
//  cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one vertex per cycle while the pipeline is not held; a vertex passes in order
// through s0, the one-bit-per-stage divider lanes, the 30-stage cordic and scale.
// rst is synchronous and clears all valid bits and config to reset values.
// the pipeline holds only when the output is stalled and its last stage is full;
// bubbles keep collapsing while a result waits.
`timescale 1ns / 1ps
`default_nettype none
module uv_sphere_vertex_generator #(
  parameter int MAX_DIVISIONS = 256,
  parameter int PHASE_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [uvs_pkg::CNT_W-1:0]      stack_index,
  input  wire logic [uvs_pkg::CNT_W-1:0]      sector_index,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [uvs_pkg::FIELD_W-1:0]  pos_x,
  output logic signed [uvs_pkg::FIELD_W-1:0]  pos_y,
  output logic signed [uvs_pkg::FIELD_W-1:0]  pos_z,
  output logic [uvs_pkg::FIELD_W-1:0]         tex_u,
  output logic [uvs_pkg::FIELD_W-1:0]         tex_v,
  output logic signed [uvs_pkg::FIELD_W-1:0]  normal_x,
  output logic signed [uvs_pkg::FIELD_W-1:0]  normal_y,
  output logic signed [uvs_pkg::FIELD_W-1:0]  normal_z,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [uvs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [uvs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import uvs_pkg::*;

  localparam int IW = $clog2(MAX_DIVISIONS + 1);
  localparam int QW = ((PHASE_BITS > TEX_SHIFT) ? PHASE_BITS : TEX_SHIFT) + 1;
  localparam int TEX_LAT = CORDIC_LAT + SCALE_LAT;
  localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);

  logic [CNT_W-1:0] stack_count, sector_count;
  logic [RADIUS_W-1:0] sphere_radius;
  logic [31:0] stk_w, sec_w, st_w, se_w;
  logic [IW-1:0] stk_c, sec_c;
  logic hold, adv;
  logic s0_valid;
  logic [IW-1:0] s0_st, s0_se;
  logic d_valid, c_valid, sc_valid;
  logic [QW-1:0] q_sp, q_ep, q_u, q_v;
  logic [PHASE_BITS-1:0] sp;
  trig_t cs, ss, cc, sc;
  field_t tu_d [TEX_LAT];
  field_t tv_d [TEX_LAT];
  field_t px, py, pz;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count   <= 9'd32;
      sector_count  <= 9'd32;
      sphere_radius <= 16'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STACK_COUNT:  stack_count   <= cfg_data[CNT_W-1:0];
        CFG_SECTOR_COUNT: sector_count  <= cfg_data[CNT_W-1:0];
        CFG_RADIUS:       sphere_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    stk_w = (stack_count == '0) ? 32'd1 :
            ((32'(stack_count) > 32'(MAX_DIVISIONS)) ? 32'(MAX_DIVISIONS)
                                                     : 32'(stack_count));
    sec_w = (sector_count == '0) ? 32'd1 :
            ((32'(sector_count) > 32'(MAX_DIVISIONS)) ? 32'(MAX_DIVISIONS)
                                                      : 32'(sector_count));
    stk_c = stk_w[IW-1:0];
    sec_c = sec_w[IW-1:0];
    st_w  = (32'(stack_index) > 32'(stk_c)) ? 32'(stk_c) : 32'(stack_index);
    se_w  = (32'(sector_index) > 32'(sec_c)) ? 32'(sec_c) : 32'(sector_index);
  end

  assign hold     = out_valid && out_stall && sc_valid;
  assign adv      = !hold;
  assign in_stall = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
    end
    if (adv) begin
      s0_st <= st_w[IW-1:0];
      s0_se <= se_w[IW-1:0];
    end
  end

  uvs_div_lane #(.IW(IW), .QW(QW), .SHIFT(PHASE_BITS - 1)) u_div_sp (
    .clk(clk), .rst(rst), .en(adv), .vin(s0_valid), .idx(s0_st), .cnt(stk_c),
    .vout(d_valid), .quo(q_sp));
  uvs_div_lane #(.IW(IW), .QW(QW), .SHIFT(PHASE_BITS)) u_div_ep (
    .clk(clk), .rst(rst), .en(adv), .vin(s0_valid), .idx(s0_se), .cnt(sec_c),
    .vout(), .quo(q_ep));
  uvs_div_lane #(.IW(IW), .QW(QW), .SHIFT(TEX_SHIFT)) u_div_u (
    .clk(clk), .rst(rst), .en(adv), .vin(s0_valid), .idx(s0_se), .cnt(sec_c),
    .vout(), .quo(q_u));
  uvs_div_lane #(.IW(IW), .QW(QW), .SHIFT(TEX_SHIFT)) u_div_v (
    .clk(clk), .rst(rst), .en(adv), .vin(s0_valid), .idx(s0_st), .cnt(stk_c),
    .vout(), .quo(q_v));

  assign sp = QUARTER - q_sp[PHASE_BITS-1:0];

  uvs_cordic #(.PB(PHASE_BITS)) u_cor_st (
    .clk(clk), .rst(rst), .en(adv), .vin(d_valid), .phase(sp),
    .vout(c_valid), .cos_o(cs), .sin_o(ss));
  uvs_cordic #(.PB(PHASE_BITS)) u_cor_se (
    .clk(clk), .rst(rst), .en(adv), .vin(d_valid), .phase(q_ep[PHASE_BITS-1:0]),
    .vout(), .cos_o(cc), .sin_o(sc));

  always_ff @(posedge clk) begin
    if (adv) begin
      tu_d[0] <= q_u[FIELD_W-1:0];
      tv_d[0] <= q_v[FIELD_W-1:0];
      for (int i = 1; i < TEX_LAT; i++) begin
        tu_d[i] <= tu_d[i-1];
        tv_d[i] <= tv_d[i-1];
      end
    end
  end

  uvs_scale u_scale (
    .clk(clk), .rst(rst), .en(adv), .vin(c_valid), .radius(sphere_radius),
    .cs(cs), .ss(ss), .cc(cc), .sc(sc),
    .vout(sc_valid), .px(px), .py(py), .pz(pz));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!(out_valid && out_stall)) begin
      out_valid <= sc_valid;
    end
    if (!(out_valid && out_stall)) begin
      pos_x    <= px;
      pos_y    <= py;
      pos_z    <= pz;
      normal_x <= px;
      normal_y <= py;
      normal_z <= pz;
      tex_u    <= tu_d[TEX_LAT-1];
      tex_v    <= tv_d[TEX_LAT-1];
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/uvs_checker.sv =====
// port-level checker for the uv sphere vertex generator, bound to the top
`timescale 1ns / 1ps
`default_nettype none
`include "uv_sphere_vertex_generator_assert.svh"
module uvs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [16:0] pos_x,
  input wire logic [16:0] pos_z,
  input wire logic [16:0] tex_u,
  input wire logic [16:0] normal_x,
  input wire logic [16:0] normal_z
);
  `UVS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `UVS_ASSERT_NEXT(a_tex_stable, clk, rst, out_valid && out_stall, $stable(tex_u))
  `UVS_ASSERT_NOW(a_normal_eq, clk, rst, out_valid, normal_x == pos_x && normal_z == pos_z)
  `UVS_ASSERT_NOW(a_tex_range, clk, rst, out_valid, tex_u <= 17'd65536)
  `UVS_ASSERT_NEXT(a_reset_clear, clk, 1'b0, rst, !out_valid)
endmodule

bind uv_sphere_vertex_generator uvs_checker u_uvs_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .pos_x(pos_x), .pos_z(pos_z), .tex_u(tex_u),
  .normal_x(normal_x), .normal_z(normal_z));
`default_nettype wire
